/* hw/rtl/lwkd_pkg.sv */
// shared types and constants of the longest k-distinct window block
package lwkd_pkg;

  localparam int unsigned LetterW  = 5;
  localparam int unsigned LenW     = 13;
  localparam int unsigned MaxDistW = 5;

  localparam logic [MaxDistW-1:0] MaxDistinctReset = MaxDistW'(2);

  typedef logic [LetterW-1:0]  letter_t;
  typedef logic [LenW-1:0]     len_t;
  typedef logic [MaxDistW-1:0] max_dist_t;

  typedef struct packed {
    letter_t letter;
    logic    end_of_string;
  } in_t;

  typedef struct packed {
    len_t window_len;
    len_t best_len;
    logic final_res;
    logic overflow;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POP
  } state_e;

endpackage

/* hw/rtl/lwkd_ring.sv */
// ring store of the letters inside the window, one write and one registered read port
module lwkd_ring #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [ADDR_W-1:0]       waddr_i,
  input  lwkd_pkg::letter_t       wdata_i,
  input  logic [ADDR_W-1:0]       raddr_i,
  output lwkd_pkg::letter_t       rdata_o
);

  lwkd_pkg::letter_t mem_q [DEPTH];
  lwkd_pkg::letter_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/longest_window_k_distinct.sv */
// Longest window holding at most max_distinct distinct letters, fed one letter per input beat.
// Each letter beat yields one result beat with the current window length, the best length so
// far, the end flag and a sticky overflow flag; the end-of-string beat carries the final answer
// and clears all string state, max_distinct excepted. A letter is accepted in ST_IDLE, then
// checked and emitted in ST_CHECK when the output register is free; each letter dropped from the
// window's left adds an ST_POP and another ST_CHECK, one at a time through the ring store's
// registered read port and the per-letter count table, and each letter is dropped at most once.
// The next letter is taken while a finished result still waits in the output register.
// Letters at or above ALPHABET leave the window unchanged; letters past MAX_LEN set overflow.
module longest_window_k_distinct #(
  parameter int unsigned MAX_LEN  = 4096,
  parameter int unsigned ALPHABET = 26
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lwkd_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lwkd_pkg::out_t      out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  lwkd_pkg::max_dist_t cfg_data_i
);

  localparam int unsigned POS_W  = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_LEN);
  localparam int unsigned AIDX_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned DIST_W = $clog2(ALPHABET + 1);

  lwkd_pkg::state_e    state_q, state_d;
  lwkd_pkg::max_dist_t max_q;
  logic [POS_W-1:0]    cnt_q [ALPHABET];
  logic [POS_W-1:0]    head_q, tail_q;
  logic [DIST_W-1:0]   distinct_q;
  logic [POS_W-1:0]    best_q;
  logic                ovf_q;
  logic                last_q;
  logic                out_valid_q;
  lwkd_pkg::out_t      out_q;

  logic                in_accept;
  logic                letter_ok;
  logic                room;
  logic                add_en, ovf_set, pop_en, emit;
  logic                shrink;
  logic                out_free;
  logic [AIDX_W-1:0]   cnt_idx;
  logic [POS_W-1:0]    cnt_rd;
  lwkd_pkg::letter_t   old_letter;
  logic [POS_W-1:0]    win_len;
  logic [POS_W-1:0]    best_new;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == lwkd_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign letter_ok   = 32'(in_data_i.letter) < ALPHABET;
  assign room        = tail_q < POS_W'(MAX_LEN);
  assign shrink      = (32'(distinct_q) > 32'(max_q)) && (head_q < tail_q);
  assign out_free    = !out_valid_q || out_ready_i;
  assign win_len     = tail_q - head_q;
  assign best_new    = (win_len > best_q) ? win_len : best_q;

  lwkd_ring #(
    .DEPTH  (MAX_LEN),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (add_en),
    .waddr_i (tail_q[ADDR_W-1:0]),
    .wdata_i (in_data_i.letter),
    .raddr_i (head_q[ADDR_W-1:0]),
    .rdata_o (old_letter)
  );

  // one count table port, shared by the add and the drop steps
  always_comb begin
    if (state_q == lwkd_pkg::ST_POP) begin
      cnt_idx = AIDX_W'(old_letter);
    end else if (letter_ok) begin
      cnt_idx = AIDX_W'(in_data_i.letter);
    end else begin
      cnt_idx = '0;
    end
  end
  assign cnt_rd = cnt_q[cnt_idx];

  always_comb begin
    state_d = state_q;
    case (state_q)
      lwkd_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = lwkd_pkg::ST_CHECK;
        end
      end
      lwkd_pkg::ST_CHECK: begin
        if (shrink) begin
          state_d = lwkd_pkg::ST_POP;
        end else if (out_free) begin
          state_d = lwkd_pkg::ST_IDLE;
        end
      end
      lwkd_pkg::ST_POP: begin
        state_d = lwkd_pkg::ST_CHECK;
      end
      default: begin
        state_d = lwkd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    add_en  = 1'b0;
    ovf_set = 1'b0;
    pop_en  = 1'b0;
    emit    = 1'b0;
    case (state_q)
      lwkd_pkg::ST_IDLE: begin
        add_en  = in_accept && letter_ok && room;
        ovf_set = in_accept && letter_ok && !room;
      end
      lwkd_pkg::ST_CHECK: begin
        emit = !shrink && out_free;
      end
      lwkd_pkg::ST_POP: begin
        pop_en = 1'b1;
      end
      default: begin
        add_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lwkd_pkg::ST_IDLE;
      max_q   <= lwkd_pkg::MaxDistinctReset;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
    end
  end

  // string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_q[i] <= '0;
      end
      head_q     <= '0;
      tail_q     <= '0;
      distinct_q <= '0;
      best_q     <= '0;
      ovf_q      <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      if (in_accept) begin
        last_q <= in_data_i.end_of_string;
      end
      if (add_en) begin
        tail_q         <= tail_q + POS_W'(1);
        cnt_q[cnt_idx] <= cnt_rd + POS_W'(1);
        if (cnt_rd == '0) begin
          distinct_q <= distinct_q + DIST_W'(1);
        end
      end
      if (ovf_set) begin
        ovf_q <= 1'b1;
      end
      if (pop_en) begin
        head_q <= head_q + POS_W'(1);
        if (cnt_rd != '0) begin
          cnt_q[cnt_idx] <= cnt_rd - POS_W'(1);
          if (cnt_rd == POS_W'(1) && distinct_q != '0) begin
            distinct_q <= distinct_q - DIST_W'(1);
          end
        end
      end
      if (emit) begin
        if (last_q) begin
          for (int i = 0; i < ALPHABET; i++) begin
            cnt_q[i] <= '0;
          end
          head_q     <= '0;
          tail_q     <= '0;
          distinct_q <= '0;
          best_q     <= '0;
          ovf_q      <= 1'b0;
        end else begin
          best_q <= best_new;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.window_len <= lwkd_pkg::len_t'(win_len);
      out_q.best_len   <= lwkd_pkg::len_t'(best_new);
      out_q.final_res  <= last_q;
      out_q.overflow   <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("window start passed its end");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= POS_W'(MAX_LEN))
    else $error("string length beyond store depth");

  a_emit_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (32'(distinct_q) <= 32'(max_q) || head_q == tail_q))
    else $error("result emitted with too many distinct letters");

  a_pop_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_en |-> cnt_rd != '0)
    else $error("dropped letter has zero count");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && last_q |=> tail_q == '0 && head_q == '0 && distinct_q == '0 && !ovf_q)
    else $error("string state not cleared after end beat");

endmodule
